// File: src/pvc_pkg.sv
// Shared types, widths and the CORDIC arctangent table for the plaquette vortex counter.
// No dependencies; every other source file imports this package.
package pvc_pkg;

   localparam int SPIN_W     = 16;
   localparam int ANGLE_W    = 16;
   localparam int GUARD_W    = 20;
   localparam int XY_W       = SPIN_W + GUARD_W + 3;
   localparam int Z_W        = 32;
   localparam int STEP_W     = 5;
   localparam int COUNT_W    = 21;
   localparam int SUM_W      = ANGLE_W + 2;
   localparam int IN_DATA_W  = ((6 * SPIN_W + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((3 * COUNT_W + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(1048576);
   localparam logic [Z_W-1:0]     HALF_TURN = {1'b1, {(Z_W-1){1'b0}}};
   localparam logic [Z_W-1:0]     ROUND_BIAS = Z_W'(64'd1 << (Z_W - 1 - ANGLE_W));

   typedef struct packed {
      logic signed [SPIN_W-1:0] y;
      logic signed [SPIN_W-1:0] x;
   } corner_type;

   typedef corner_type [2:0] corner_arr_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [Z_W-1:0]         z;
      logic                   zero;
   } vec_type;

   typedef struct packed {
      vec_type [2:0] vec;
      logic          last;
   } item_type;

   typedef struct packed {
      logic vortex;
      logic antivortex;
      logic last;
   } wind_type;

   function automatic logic [Z_W-1:0] turn_atan(input logic [STEP_W-1:0] step);
      logic [Z_W-1:0] a;
      case (step)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2F9;
         5'd15:   a = 32'h0000517C;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A2F;
         5'd19:   a = 32'h00000517;
         5'd20:   a = 32'h0000028B;
         5'd21:   a = 32'h00000145;
         5'd22:   a = 32'h000000A2;
         5'd23:   a = 32'h00000051;
         5'd24:   a = 32'h00000028;
         5'd25:   a = 32'h00000014;
         5'd26:   a = 32'h0000000A;
         5'd27:   a = 32'h00000005;
         5'd28:   a = 32'h00000002;
         5'd29:   a = 32'h00000001;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// File: src/pvc_prep.sv
// Input stage: folds each corner spin into the right half plane and scales it for CORDIC.
// Depends on pvc_pkg.
module pvc_prep (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  pvc_pkg::corner_arr_type in_corners,
   input  logic                    in_last,
   output logic                    out_valid,
   output pvc_pkg::item_type       out_item
);
   import pvc_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      logic signed [XY_W-1:0] sx;
      logic signed [XY_W-1:0] sy;
      logic                   neg;
      item_in      = '0;
      item_in.last = in_last;
      for (int k = 0; k < 3; k++) begin
         sx  = XY_W'(in_corners[k].x);
         sy  = XY_W'(in_corners[k].y);
         neg = in_corners[k].x[SPIN_W-1];
         if (neg) begin
            sx = -sx;
            sy = -sy;
         end
         item_in.vec[k].x    = sx <<< GUARD_W;
         item_in.vec[k].y    = sy <<< GUARD_W;
         item_in.vec[k].z    = neg ? HALF_TURN : '0;
         item_in.vec[k].zero = (in_corners[k].x == '0) && (in_corners[k].y == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: src/pvc_cordic_cell.sv
// One CORDIC vectoring step applied to all three corner vectors, registered.
// Depends on pvc_pkg; chained once per angle bit in the top level.
module pvc_cordic_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [pvc_pkg::STEP_W-1:0]  step,
   input  logic                        in_valid,
   input  pvc_pkg::item_type           in_item,
   output logic                        out_valid,
   output pvc_pkg::item_type           out_item
);
   import pvc_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic [Z_W-1:0]         atan;
      atan    = turn_atan(step);
      item_in = in_item;
      for (int k = 0; k < 3; k++) begin
         x  = in_item.vec[k].x;
         y  = in_item.vec[k].y;
         xs = x >>> step;
         ys = y >>> step;
         if (!y[XY_W-1]) begin
            item_in.vec[k].x = x + ys;
            item_in.vec[k].y = y - xs;
            item_in.vec[k].z = in_item.vec[k].z + atan;
         end else begin
            item_in.vec[k].x = x - ys;
            item_in.vec[k].y = y + xs;
            item_in.vec[k].z = in_item.vec[k].z - atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: src/pvc_wind.sv
// Rounds the three angles, wraps the cyclic differences and classifies the winding.
// Depends on pvc_pkg.
module pvc_wind (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  pvc_pkg::item_type in_item,
   output logic              out_valid,
   output pvc_pkg::wind_type out_wind
);
   import pvc_pkg::*;

   logic     valid_ff;
   wind_type wind_ff;
   wind_type wind_in;

   always_comb begin
      logic [ANGLE_W-1:0]       ang [3];
      logic [Z_W-1:0]           zr;
      logic [ANGLE_W-1:0]       d;
      logic signed [SUM_W-1:0]  sum;
      for (int k = 0; k < 3; k++) begin
         zr     = in_item.vec[k].z + ROUND_BIAS;
         ang[k] = in_item.vec[k].zero ? '0 : zr[Z_W-1 -: ANGLE_W];
      end
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         d   = ang[(k + 1) % 3] - ang[k];
         sum = sum + SUM_W'(signed'(d));
      end
      wind_in.vortex     = (sum == SUM_W'(64'd1 << ANGLE_W));
      wind_in.antivortex = (sum == -SUM_W'(64'd1 << ANGLE_W));
      wind_in.last       = in_item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wind_ff <= wind_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_wind  = wind_ff;

endmodule

// File: src/plaquette_vortex_counter_unit.sv
// Plaquette vortex counter: prep stage, a chain of CORDIC cells, winding stage, counters.
// Depends on pvc_pkg, pvc_prep, pvc_cordic_cell and pvc_wind.
// Throughput: one plaquette per cycle; the whole chain stalls only while a count result waits.
// Path to the count result: prep, CORDIC cell, winding and response registers, in that order.
// Reset: synchronous, clears all valid bits and the three counters.
module plaquette_vortex_counter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y
   input  logic [pvc_pkg::IN_DATA_W-1:0]    req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // vortex_total, antivortex_total, plaquette_total, zero pad
   output logic [pvc_pkg::OUT_DATA_W-1:0]   rsp_tdata
);
   import pvc_pkg::*;

   logic           advance;
   corner_arr_type corners;
   logic           chain_valid [ANGLE_W+1];
   item_type       chain_item  [ANGLE_W+1];
   logic           wind_valid;
   wind_type       wind;

   logic [COUNT_W-1:0] vortex_ff;
   logic [COUNT_W-1:0] vortex_in;
   logic [COUNT_W-1:0] anti_ff;
   logic [COUNT_W-1:0] anti_in;
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] total_in;
   logic               rsp_valid_ff;
   logic [3*COUNT_W-1:0] rsp_data_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign corners    = corner_arr_type'(req_tdata[6*SPIN_W-1:0]);

   pvc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_corners(corners),
      .in_last   (req_tlast),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar g = 0; g < ANGLE_W; g++) begin : g_cell
      pvc_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .step     (STEP_W'(g)),
         .in_valid (chain_valid[g]),
         .in_item  (chain_item[g]),
         .out_valid(chain_valid[g+1]),
         .out_item (chain_item[g+1])
      );
   end

   pvc_wind u_wind (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (chain_valid[ANGLE_W]),
      .in_item  (chain_item[ANGLE_W]),
      .out_valid(wind_valid),
      .out_wind (wind)
   );

   always_comb begin
      vortex_in = vortex_ff;
      anti_in   = anti_ff;
      if (wind.vortex && vortex_ff < MAX_COUNT) begin
         vortex_in = vortex_ff + 1'b1;
      end
      if (wind.antivortex && anti_ff < MAX_COUNT) begin
         anti_in = anti_ff + 1'b1;
      end
      total_in = (total_ff < MAX_COUNT) ? total_ff + 1'b1 : total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vortex_ff    <= '0;
         anti_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= wind_valid && wind.last;
         if (wind_valid) begin
            if (wind.last) begin
               vortex_ff <= '0;
               anti_ff   <= '0;
               total_ff  <= '0;
            end else begin
               vortex_ff <= vortex_in;
               anti_ff   <= anti_in;
               total_ff  <= total_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wind_valid && wind.last) begin
         rsp_data_ff <= {total_in, anti_in, vortex_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'(rsp_data_ff);

endmodule
